/* hw/rtl/dacc_pkg.sv */
// ----------------------------------------------------------------------------
// dacc_pkg
// Shared types and constants of the decimal accumulator processor.
// ----------------------------------------------------------------------------
`default_nettype none

package dacc_pkg;

   localparam int ADDR_W = 7;
   localparam int WORD_W = 16;
   localparam int ACC_W  = 32;
   localparam int INBOX_W = 10;

   // request kinds carried on tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // decimal instruction group boundaries
   localparam logic [WORD_W-1:0] WORD_ADD   = 16'd100;
   localparam logic [WORD_W-1:0] WORD_SUB   = 16'd200;
   localparam logic [WORD_W-1:0] WORD_STORE = 16'd300;
   localparam logic [WORD_W-1:0] WORD_LOAD  = 16'd500;
   localparam logic [WORD_W-1:0] WORD_JUMP  = 16'd600;
   localparam logic [WORD_W-1:0] WORD_JZ    = 16'd700;
   localparam logic [WORD_W-1:0] WORD_JNZ   = 16'd800;
   localparam logic [WORD_W-1:0] WORD_IO    = 16'd900;
   localparam logic [WORD_W-1:0] WORD_HALT  = 16'd0;

   localparam logic [ADDR_W-1:0]  IO_INPUT  = 7'd1;
   localparam logic [ADDR_W-1:0]  IO_OUTPUT = 7'd2;
   localparam logic [INBOX_W-1:0] INBOX_MAX = 10'd999;

   // floor(x / 100) = (x * MAGIC_RECIP) >> MAGIC_SHIFT for any 16-bit x
   localparam logic [16:0] MAGIC_RECIP = 17'd83887;
   localparam int          MAGIC_SHIFT = 23;

   typedef enum logic [2:0] {
      ST_LOADED   = 3'd0,
      ST_EXECUTED = 3'd1,
      ST_HALTED   = 3'd2,
      ST_UNKNOWN  = 3'd3,
      ST_REJECTED = 3'd4,
      ST_IGNORED  = 3'd5
   } status_type;

   typedef struct packed {
      status_type        status;
      logic              outbox_valid;
      logic [ACC_W-1:0]  outbox_value;
      logic [ACC_W-1:0]  acc_next;
      logic [ADDR_W-1:0] pc_next;
      logic              halt_set;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic [WORD_W-1:0] word;
      logic [ADDR_W-1:0] opnd_addr;
   } exec_out_type;

endpackage

`default_nettype wire

/* hw/rtl/dacc_mbox.sv */
// ----------------------------------------------------------------------------
// dacc_mbox
// Mailbox store: one write port, two registered read ports, valid bits so
// that unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dacc_mbox #(
   parameter int DEPTH = 100
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [dacc_pkg::ADDR_W-1:0]   wr_addr,
   input  wire logic [dacc_pkg::WORD_W-1:0]   wr_data,
   input  wire logic [dacc_pkg::ADDR_W-1:0]   rd_a_addr,
   output logic      [dacc_pkg::WORD_W-1:0]   rd_a_data,
   input  wire logic [dacc_pkg::ADDR_W-1:0]   rd_b_addr,
   output logic      [dacc_pkg::WORD_W-1:0]   rd_b_data
);

   logic [dacc_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]            valid_ff;
   logic [dacc_pkg::WORD_W-1:0] rd_a_ff;
   logic [dacc_pkg::WORD_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // a write in the same cycle is forwarded to the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_a_ff <= '0;
         rd_b_ff <= '0;
      end else begin
         if (wr_en && (wr_addr == rd_a_addr)) begin
            rd_a_ff <= wr_data;
         end else if (valid_ff[rd_a_addr]) begin
            rd_a_ff <= mem_ff[rd_a_addr];
         end else begin
            rd_a_ff <= '0;
         end
         if (wr_en && (wr_addr == rd_b_addr)) begin
            rd_b_ff <= wr_data;
         end else if (valid_ff[rd_b_addr]) begin
            rd_b_ff <= mem_ff[rd_b_addr];
         end else begin
            rd_b_ff <= '0;
         end
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

/* hw/rtl/dacc_exec.sv */
// ----------------------------------------------------------------------------
// dacc_exec
// Decode and execute of one request: mailbox load or one instruction step.
// ----------------------------------------------------------------------------
`default_nettype none

module dacc_exec #(
   parameter int MAILBOX_COUNT = 100
) (
   input  wire logic                          req_kind,
   input  wire logic [dacc_pkg::ADDR_W-1:0]   load_address,
   input  wire logic [dacc_pkg::WORD_W-1:0]   load_value,
   input  wire logic [dacc_pkg::INBOX_W-1:0]  inbox_value,
   input  wire logic [dacc_pkg::WORD_W-1:0]   fetch_word,
   input  wire logic [dacc_pkg::WORD_W-1:0]   opnd_word,
   input  wire logic [dacc_pkg::ACC_W-1:0]    acc,
   input  wire logic [dacc_pkg::ADDR_W-1:0]   pc,
   input  wire logic                          halted,
   output dacc_pkg::exec_out_type             result
);

   localparam logic [dacc_pkg::ADDR_W-1:0] LastBox = dacc_pkg::ADDR_W'(MAILBOX_COUNT - 1);
   localparam logic [dacc_pkg::ADDR_W-1:0] BoxCount = dacc_pkg::ADDR_W'(MAILBOX_COUNT);

   function automatic logic [dacc_pkg::ADDR_W-1:0] mod_hundred(
      input logic [dacc_pkg::WORD_W-1:0] value
   );
      logic [32:0] prod;
      logic [9:0]  quot;
      logic [15:0] rest;
      prod = 33'(value) * 33'(dacc_pkg::MAGIC_RECIP);
      quot = prod[32:dacc_pkg::MAGIC_SHIFT];
      rest = value - 16'(quot) * 16'd100;
      return rest[dacc_pkg::ADDR_W-1:0];
   endfunction

   logic [dacc_pkg::ADDR_W-1:0] opnd_addr;
   logic [dacc_pkg::ADDR_W-1:0] pc_inc;
   logic [dacc_pkg::ACC_W-1:0]  opnd_ext;

   assign opnd_addr = mod_hundred(fetch_word);
   assign pc_inc    = (pc >= LastBox) ? '0 : pc + 1'b1;
   assign opnd_ext  = {{(dacc_pkg::ACC_W - dacc_pkg::WORD_W){1'b0}}, opnd_word};

   always_comb begin
      result              = '0;
      result.status       = dacc_pkg::ST_EXECUTED;
      result.acc_next     = acc;
      result.pc_next      = pc;
      result.wr_addr      = opnd_addr;
      result.wr_data      = acc[dacc_pkg::WORD_W-1:0];
      result.opnd_addr    = opnd_addr;
      if (req_kind == dacc_pkg::REQ_LOAD) begin
         result.status  = dacc_pkg::ST_LOADED;
         result.wr_en   = (load_address < BoxCount);
         result.wr_addr = load_address;
         result.wr_data = load_value;
      end else if (halted) begin
         result.status = dacc_pkg::ST_IGNORED;
      end else begin
         result.word    = fetch_word;
         result.pc_next = pc_inc;
         if (fetch_word >= dacc_pkg::WORD_IO) begin
            if (opnd_addr == dacc_pkg::IO_INPUT) begin
               if (inbox_value > dacc_pkg::INBOX_MAX) begin
                  result.status  = dacc_pkg::ST_REJECTED;
                  result.pc_next = pc;
               end else begin
                  result.acc_next = {{(dacc_pkg::ACC_W - dacc_pkg::INBOX_W){1'b0}},
                                     inbox_value};
               end
            end else if (opnd_addr == dacc_pkg::IO_OUTPUT) begin
               result.outbox_valid = 1'b1;
               result.outbox_value = acc;
            end
         end else if (fetch_word >= dacc_pkg::WORD_JNZ) begin
            if (acc != '0) begin
               result.pc_next = opnd_addr;
            end
         end else if (fetch_word >= dacc_pkg::WORD_JZ) begin
            if (acc == '0) begin
               result.pc_next = opnd_addr;
            end
         end else if (fetch_word >= dacc_pkg::WORD_JUMP) begin
            result.pc_next = opnd_addr;
         end else if (fetch_word >= dacc_pkg::WORD_LOAD) begin
            result.acc_next = opnd_ext;
         end else if (fetch_word >= dacc_pkg::WORD_STORE) begin
            result.wr_en = (opnd_addr < BoxCount);
         end else if (fetch_word >= dacc_pkg::WORD_SUB) begin
            result.acc_next = acc - opnd_ext;
         end else if (fetch_word >= dacc_pkg::WORD_ADD) begin
            result.acc_next = acc + opnd_ext;
         end else if (fetch_word == dacc_pkg::WORD_HALT) begin
            result.status   = dacc_pkg::ST_HALTED;
            result.halt_set = 1'b1;
            result.pc_next  = pc;
         end else begin
            result.status   = dacc_pkg::ST_UNKNOWN;
            result.halt_set = 1'b1;
            result.pc_next  = pc;
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/decimal_accumulator_cpu_step_top.sv */
// ----------------------------------------------------------------------------
// decimal_accumulator_cpu_step_top
// Toy decimal accumulator processor: 100 sixteen-bit mailboxes, a 32-bit
// accumulator, a program counter and a halted flag, driven by requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: tuser 0 writes a mailbox word, tuser 1 runs one
//   instruction at the program counter. rsp_* returns exactly one response
//   per request, in order, with status, outbox and the state after it.
//   Latency: the response is valid in the cycle after the request is taken.
//   Throughput: loads and steps while halted go at one per cycle while the
//   response is taken. A step needs the operand word, read from the mailbox
//   port that follows the registered fetch word; after a step that moves the
//   counter, or a write to the mailbox under the counter, the next step waits
//   until that operand read has settled, taken jumps included. A step that
//   leaves the counter in place (rejected inbox, jump to its own mailbox)
//   lets the next step follow at once.
//   Reset: counter, accumulator and halted flag clear; per-word valid bits
//   make every mailbox read as zero at once, with no clearing pass.
//   A stalled response is held in the output register; a new request is
//   taken in the cycle the held response leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_accumulator_cpu_step_top #(
   parameter int MAILBOX_COUNT = 100
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // load_address [6:0], load_value [22:7], inbox_value [32:23], zero pad
   input  wire logic [39:0] req_tdata,
   // req_type [0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // outbox_value [31:0], acc_now [63:32], pc_now [70:64],
   // executed_word [86:71], zero pad
   output logic [87:0]      rsp_tdata,
   // status [2:0], outbox_valid [3]
   output logic [3:0]       rsp_tuser
);

   localparam int AW = dacc_pkg::ADDR_W;
   localparam int WW = dacc_pkg::WORD_W;
   localparam int CW = dacc_pkg::ACC_W;

   logic [CW-1:0] acc_ff, acc_in;
   logic [AW-1:0] pc_ff, pc_in;
   logic          halted_ff, halted_in;
   logic          opnd_ok_ff, opnd_ok_in;

   logic                  rsp_valid_ff;
   dacc_pkg::status_type  rsp_status_ff;
   logic                  rsp_ovalid_ff;
   logic [CW-1:0]         rsp_oval_ff;
   logic [CW-1:0]         rsp_acc_ff;
   logic [AW-1:0]         rsp_pc_ff;
   logic [WW-1:0]         rsp_word_ff;

   logic [WW-1:0]          fetch_word;
   logic [WW-1:0]          opnd_word;
   dacc_pkg::exec_out_type exec_res;
   logic                   out_free;
   logic                   accept;
   logic                   wr_en;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   // a step must wait until the operand read has settled
   assign req_tready = out_free && (opnd_ok_ff || halted_ff ||
                                    (req_tuser == dacc_pkg::REQ_LOAD));
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && exec_res.wr_en;

   dacc_exec #(
      .MAILBOX_COUNT (MAILBOX_COUNT)
   ) u_exec (
      .req_kind     (req_tuser),
      .load_address (req_tdata[6:0]),
      .load_value   (req_tdata[22:7]),
      .inbox_value  (req_tdata[32:23]),
      .fetch_word   (fetch_word),
      .opnd_word    (opnd_word),
      .acc          (acc_ff),
      .pc           (pc_ff),
      .halted       (halted_ff),
      .result       (exec_res)
   );

   dacc_mbox #(
      .DEPTH (MAILBOX_COUNT)
   ) u_mbox (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (exec_res.wr_addr),
      .wr_data   (exec_res.wr_data),
      .rd_a_addr (pc_in),
      .rd_a_data (fetch_word),
      .rd_b_addr (exec_res.opnd_addr),
      .rd_b_data (opnd_word)
   );

   always_comb begin
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      if (accept) begin
         acc_in    = exec_res.acc_next;
         pc_in     = exec_res.pc_next;
         halted_in = halted_ff || exec_res.halt_set;
      end
      // the fetch word stays put, so this cycle's operand read is good next cycle
      opnd_ok_in = (pc_in == pc_ff) && !(wr_en && (exec_res.wr_addr == pc_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         opnd_ok_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         pc_ff      <= pc_in;
         halted_ff  <= halted_in;
         opnd_ok_ff <= opnd_ok_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= exec_res.status;
         rsp_ovalid_ff <= exec_res.outbox_valid;
         rsp_oval_ff   <= exec_res.outbox_value;
         rsp_acc_ff    <= exec_res.acc_next;
         rsp_pc_ff     <= exec_res.pc_next;
         rsp_word_ff   <= exec_res.word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ovalid_ff, rsp_status_ff};
   assign rsp_tdata  = {1'b0, rsp_word_ff, rsp_pc_ff, rsp_acc_ff, rsp_oval_ff};

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff < AW'(MAILBOX_COUNT))
      else $error("program counter beyond the last mailbox");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   a_halted_step: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == dacc_pkg::REQ_STEP) && halted_ff) |=>
      (rsp_tuser[2:0] == dacc_pkg::ST_IGNORED) && (rsp_tdata[70:64] == $past(pc_ff)))
      else $error("step while halted was not ignored");

   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(accept))
      else $error("response appeared without a request");

endmodule

`default_nettype wire
